FILE: rtl/aminv_pkg.sv
// ----------------------------------------------------------------------------
// aminv_pkg
// Shared constants, types and helpers for the affine matrix inverse pipeline.
// ----------------------------------------------------------------------------
package aminv_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST  = 2'd2;

    // Per-slot control that travels with the data down the pipeline.
    typedef struct packed {
        logic       valid;
        logic [1:0] row;
    } t_ctl;

    // Row index plus one, modulo three.
    function automatic logic [1:0] row_next(input logic [1:0] r);
        return (r == ROW_LAST) ? ROW_FIRST : r + 2'd1;
    endfunction

endpackage

FILE: rtl/aminv_mat_if.sv
// ----------------------------------------------------------------------------
// aminv_mat_if
// Matrix channel: valid/ready with the twelve elements of a 3x4 matrix.
// ----------------------------------------------------------------------------
interface aminv_mat_if #(
    parameter int W = aminv_pkg::WORD_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] r0c0;
    logic signed [W-1:0] r0c1;
    logic signed [W-1:0] r0c2;
    logic signed [W-1:0] r0c3;
    logic signed [W-1:0] r1c0;
    logic signed [W-1:0] r1c1;
    logic signed [W-1:0] r1c2;
    logic signed [W-1:0] r1c3;
    logic signed [W-1:0] r2c0;
    logic signed [W-1:0] r2c1;
    logic signed [W-1:0] r2c2;
    logic signed [W-1:0] r2c3;

    modport source (
        output valid, r0c0, r0c1, r0c2, r0c3, r1c0, r1c1, r1c2, r1c3,
               r2c0, r2c1, r2c2, r2c3,
        input  ready
    );
    modport sink (
        input  valid, r0c0, r0c1, r0c2, r0c3, r1c0, r1c1, r1c2, r1c3,
               r2c0, r2c1, r2c2, r2c3,
        output ready
    );
endinterface

FILE: rtl/aminv_row_if.sv
// ----------------------------------------------------------------------------
// aminv_row_if
// Result channel: valid/ready with one row of the inverse and its flags.
// ----------------------------------------------------------------------------
interface aminv_row_if #(
    parameter int W = aminv_pkg::WORD_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [1:0]          row_index;
    logic signed [W-1:0] out_c0;
    logic signed [W-1:0] out_c1;
    logic signed [W-1:0] out_c2;
    logic signed [W-1:0] out_c3;
    logic                singular;
    logic                overflow;
    logic                last;

    modport source (
        output valid, row_index, out_c0, out_c1, out_c2, out_c3, singular,
               overflow, last,
        input  ready
    );
    modport sink (
        input  valid, row_index, out_c0, out_c1, out_c2, out_c3, singular,
               overflow, last,
        output ready
    );
endinterface

FILE: rtl/aminv_front.sv
// ----------------------------------------------------------------------------
// aminv_front
// Cofactors, determinant and divider setup for one row slot (seven stages).
// ----------------------------------------------------------------------------
module aminv_front #(
    parameter int W = aminv_pkg::WORD_BITS_DEF,
    parameter int F = aminv_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  aminv_pkg::t_ctl            i_ctl,
    input  logic [2:0][3:0][W-1:0]     i_mat,
    output aminv_pkg::t_ctl            o_ctl,
    output logic [3*W+1:0]             o_d,
    output logic [2:0][3*W+2:0]        o_rem,
    output logic [2:0][W-1:0]          o_nlo,
    output logic [2:0]                 o_neg,
    output logic [2:0]                 o_povf,
    output logic                       o_sing,
    output logic [2:0][W-1:0]          o_t
);
    import aminv_pkg::*;

    localparam int CW  = 2*W + 1;     // signed cofactor
    localparam int CMW = 2*W;         // cofactor magnitude
    localparam int DW  = 3*W + 3;     // signed determinant
    localparam int DMW = 3*W + 2;     // determinant magnitude
    localparam int RW  = DMW + 1;     // divider remainder
    localparam int NW  = CMW + 2*F;   // scaled numerator
    localparam int NHW = NW - W;
    localparam int CPW = (NHW > DMW) ? NHW : DMW;

    logic [1:0] w_i1, w_i2;
    assign w_i1 = row_next(i_ctl.row);
    assign w_i2 = row_next(w_i1);

    // stage 1: products
    t_ctl                r1_ctl;
    logic signed [2*W-1:0] r1_pa [3], r1_pb [3], r1_qa [3], r1_qb [3];
    logic signed [W-1:0]   r1_m0 [3], r1_t [3];
    // stage 2: cofactors of this row and of row 0
    t_ctl                r2_ctl;
    logic signed [CW-1:0]  r2_ci [3], r2_c0 [3];
    logic signed [W-1:0]   r2_m0 [3], r2_t [3];
    // stage 3: determinant partial products
    t_ctl                r3_ctl;
    logic signed [2*W:0]   r3_plo [3], r3_phi [3];
    logic signed [CW-1:0]  r3_ci [3];
    logic signed [W-1:0]   r3_t [3];
    // stage 4: per-column determinant terms
    t_ctl                r4_ctl;
    logic signed [DW-1:0]  r4_dj [3];
    logic signed [CW-1:0]  r4_ci [3];
    logic signed [W-1:0]   r4_t [3];
    // stage 5: determinant
    t_ctl                r5_ctl;
    logic signed [DW-1:0]  r5_det;
    logic signed [CW-1:0]  r5_ci [3];
    logic signed [W-1:0]   r5_t [3];
    // stage 6: magnitudes and signs
    t_ctl                r6_ctl;
    logic [DMW-1:0]        r6_dmag;
    logic                  r6_sing;
    logic [CMW-1:0]        r6_cmag [3];
    logic [2:0]            r6_neg;
    logic signed [W-1:0]   r6_t [3];
    // stage 7: divider setup
    t_ctl                r7_ctl;
    logic [DMW-1:0]        r7_d;
    logic [2:0][RW-1:0]    r7_rem;
    logic [2:0][W-1:0]     r7_nlo;
    logic [2:0]            r7_neg, r7_povf;
    logic                  r7_sing;
    logic [2:0][W-1:0]     r7_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
            r5_ctl <= '0;
            r6_ctl <= '0;
            r7_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
            r5_ctl <= r4_ctl;
            r6_ctl <= r5_ctl;
            r7_ctl <= r6_ctl;
        end
    end

    genvar j;
    for (j = 0; j < 3; j++) begin : g_col
        localparam int J1 = (j + 1) % 3;
        localparam int J2 = (j + 2) % 3;

        logic signed [DW-1:0] w_dabs;
        logic signed [CW-1:0] w_cabs;
        logic [NW-1:0]        w_n;
        logic [NHW-1:0]       w_nhi;

        assign w_dabs = r5_det[DW-1] ? -r5_det : r5_det;
        assign w_cabs = r5_ci[j][CW-1] ? -r5_ci[j] : r5_ci[j];
        assign w_n    = NW'(r6_cmag[j]) << (2*F);
        assign w_nhi  = w_n[NW-1:W];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r1_pa[j] <= $signed(i_mat[J1][w_i1]) * $signed(i_mat[J2][w_i2]);
                r1_pb[j] <= $signed(i_mat[J1][w_i2]) * $signed(i_mat[J2][w_i1]);
                r1_qa[j] <= $signed(i_mat[J1][1]) * $signed(i_mat[J2][2]);
                r1_qb[j] <= $signed(i_mat[J1][2]) * $signed(i_mat[J2][1]);
                r1_m0[j] <= $signed(i_mat[j][0]);
                r1_t[j]  <= $signed(i_mat[j][3]);

                r2_ci[j] <= CW'(r1_pa[j]) - CW'(r1_pb[j]);
                r2_c0[j] <= CW'(r1_qa[j]) - CW'(r1_qb[j]);
                r2_m0[j] <= r1_m0[j];
                r2_t[j]  <= r1_t[j];

                // row-0 cofactor split into unsigned low word and signed high part
                r3_plo[j] <= $signed({1'b0, r2_c0[j][W-1:0]}) * r2_m0[j];
                r3_phi[j] <= $signed(r2_c0[j][CW-1:W]) * r2_m0[j];
                r3_ci[j]  <= r2_ci[j];
                r3_t[j]   <= r2_t[j];

                r4_dj[j] <= (DW'(r3_phi[j]) <<< W) + DW'(r3_plo[j]);
                r4_ci[j] <= r3_ci[j];
                r4_t[j]  <= r3_t[j];

                r5_ci[j] <= r4_ci[j];
                r5_t[j]  <= r4_t[j];

                r6_cmag[j] <= w_cabs[CMW-1:0];
                r6_neg[j]  <= r5_ci[j][CW-1] ^ r5_det[DW-1];
                r6_t[j]    <= r5_t[j];

                r7_rem[j]  <= RW'(w_nhi);
                r7_nlo[j]  <= w_n[W-1:0];
                r7_povf[j] <= CPW'(w_nhi) >= CPW'(r6_dmag);
                r7_neg[j]  <= r6_neg[j];
                r7_t[j]    <= r6_t[j];
            end
        end

        if (j == 0) begin : g_det
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r6_dmag <= w_dabs[DMW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_det  <= r4_dj[0] + r4_dj[1] + r4_dj[2];
            r6_sing <= (r5_det == '0);
            r7_d    <= r6_dmag;
            r7_sing <= r6_sing;
        end
    end

    assign o_ctl  = r7_ctl;
    assign o_d    = r7_d;
    assign o_rem  = r7_rem;
    assign o_nlo  = r7_nlo;
    assign o_neg  = r7_neg;
    assign o_povf = r7_povf;
    assign o_sing = r7_sing;
    assign o_t    = r7_t;

endmodule

FILE: rtl/aminv_div.sv
// ----------------------------------------------------------------------------
// aminv_div
// Three-lane restoring divider, one quotient bit per stage, W stages.
// ----------------------------------------------------------------------------
module aminv_div #(
    parameter int W = aminv_pkg::WORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  aminv_pkg::t_ctl        i_ctl,
    input  logic [3*W+1:0]         i_d,
    input  logic [2:0][3*W+2:0]    i_rem,
    input  logic [2:0][W-1:0]      i_nlo,
    input  logic [2:0]             i_neg,
    input  logic [2:0]             i_povf,
    input  logic                   i_sing,
    input  logic [2:0][W-1:0]      i_t,
    output aminv_pkg::t_ctl        o_ctl,
    output logic [3*W+1:0]         o_d,
    output logic [2:0][3*W+2:0]    o_rem,
    output logic [2:0][W-1:0]      o_q,
    output logic [2:0]             o_neg,
    output logic [2:0]             o_povf,
    output logic                   o_sing,
    output logic [2:0][W-1:0]      o_t
);
    import aminv_pkg::*;

    localparam int DMW = 3*W + 2;
    localparam int RW  = DMW + 1;

    t_ctl               r_ctl  [W];
    logic [DMW-1:0]     r_d    [W];
    logic [2:0][RW-1:0] r_rem  [W];
    logic [2:0][W-1:0]  r_q    [W];
    logic [2:0][W-1:0]  r_nlo  [W];
    logic [2:0]         r_neg  [W];
    logic [2:0]         r_povf [W];
    logic               r_sing [W];
    logic [2:0][W-1:0]  r_t    [W];

    genvar s;
    for (s = 0; s < W; s++) begin : g_step
        t_ctl               p_ctl;
        logic [DMW-1:0]     p_d;
        logic [2:0][RW-1:0] p_rem;
        logic [2:0][W-1:0]  p_q;
        logic [2:0][W-1:0]  p_nlo;
        logic [2:0]         p_neg, p_povf;
        logic               p_sing;
        logic [2:0][W-1:0]  p_t;
        logic [2:0][RW-1:0] n_rem;
        logic [2:0][W-1:0]  n_q;
        logic [2:0][RW-1:0] w_sh;
        logic [2:0]         w_ge;

        if (s == 0) begin : g_head
            assign p_ctl  = i_ctl;
            assign p_d    = i_d;
            assign p_rem  = i_rem;
            assign p_q    = '0;
            assign p_nlo  = i_nlo;
            assign p_neg  = i_neg;
            assign p_povf = i_povf;
            assign p_sing = i_sing;
            assign p_t    = i_t;
        end else begin : g_body
            assign p_ctl  = r_ctl[s-1];
            assign p_d    = r_d[s-1];
            assign p_rem  = r_rem[s-1];
            assign p_q    = r_q[s-1];
            assign p_nlo  = r_nlo[s-1];
            assign p_neg  = r_neg[s-1];
            assign p_povf = r_povf[s-1];
            assign p_sing = r_sing[s-1];
            assign p_t    = r_t[s-1];
        end

        // remainder stays below the divisor, so its top bit is free for the shift
        always_comb begin
            n_q = p_q;
            for (int l = 0; l < 3; l++) begin
                w_sh[l]        = {p_rem[l][RW-2:0], p_nlo[l][W-1-s]};
                w_ge[l]        = w_sh[l] >= {1'b0, p_d};
                n_rem[l]       = w_ge[l] ? w_sh[l] - {1'b0, p_d} : w_sh[l];
                n_q[l][W-1-s]  = w_ge[l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[s] <= '0;
            end else if (i_en) begin
                r_ctl[s] <= p_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[s]    <= p_d;
                r_rem[s]  <= n_rem;
                r_q[s]    <= n_q;
                r_nlo[s]  <= p_nlo;
                r_neg[s]  <= p_neg;
                r_povf[s] <= p_povf;
                r_sing[s] <= p_sing;
                r_t[s]    <= p_t;
            end
        end
    end

    assign o_ctl  = r_ctl[W-1];
    assign o_d    = r_d[W-1];
    assign o_rem  = r_rem[W-1];
    assign o_q    = r_q[W-1];
    assign o_neg  = r_neg[W-1];
    assign o_povf = r_povf[W-1];
    assign o_sing = r_sing[W-1];
    assign o_t    = r_t[W-1];

endmodule

FILE: rtl/aminv_back.sv
// ----------------------------------------------------------------------------
// aminv_back
// Quotient rounding and saturation, translation term, output register.
// ----------------------------------------------------------------------------
module aminv_back #(
    parameter int W = aminv_pkg::WORD_BITS_DEF,
    parameter int F = aminv_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  aminv_pkg::t_ctl        i_ctl,
    input  logic [3*W+1:0]         i_d,
    input  logic [2:0][3*W+2:0]    i_rem,
    input  logic [2:0][W-1:0]      i_q,
    input  logic [2:0]             i_neg,
    input  logic [2:0]             i_povf,
    input  logic                   i_sing,
    input  logic [2:0][W-1:0]      i_t,
    output logic                   o_valid,
    output logic [1:0]             o_row,
    output logic [3:0][W-1:0]      o_c,
    output logic                   o_sing,
    output logic                   o_ovf,
    output logic                   o_last
);
    import aminv_pkg::*;

    localparam int RW = 3*W + 3;
    localparam int SW = 2*W + 3;
    localparam logic [W-1:0] MAXV     = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV     = {1'b1, {(W-1){1'b0}}};
    localparam logic         DIAG_OVF = (F > W - 2);
    localparam logic [W-1:0] DIAG     = DIAG_OVF ? MAXV : (W'(1) << F);
    localparam logic [W:0]   LIM_POS  = (W+1)'(MAXV);
    localparam logic [W:0]   LIM_NEG  = (W+1)'(MINV);
    localparam logic [SW-1:0] HALF    = SW'(1) << (F - 1);

    // stage 1: inverse elements
    t_ctl                  r1_ctl;
    logic [2:0][W-1:0]     r1_inv;
    logic                  r1_ovf, r1_sing;
    logic signed [W-1:0]   r1_t [3];
    // stage 2: translation products
    t_ctl                  r2_ctl;
    logic signed [2*W-1:0] r2_p [3];
    logic [2:0][W-1:0]     r2_inv;
    logic                  r2_ovf, r2_sing;
    // stage 3: negated sum
    t_ctl                  r3_ctl;
    logic signed [SW-1:0]  r3_ns;
    logic [2:0][W-1:0]     r3_inv;
    logic                  r3_ovf, r3_sing;
    // stage 4: output register
    t_ctl                  r4_ctl;
    logic [3:0][W-1:0]     r4_c;
    logic                  r4_ovf, r4_sing;

    logic [2:0][W-1:0] w_inv;
    logic [2:0]        w_sat;
    logic [2:0][W:0]   w_qr, w_sv;
    logic [2:0]        w_up;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_up[j]  = {i_rem[j], 1'b0} >= (RW+1)'(i_d);
            w_qr[j]  = {1'b0, i_q[j]} + (W+1)'(w_up[j]);
            w_sat[j] = i_povf[j] || (w_qr[j] > (i_neg[j] ? LIM_NEG : LIM_POS));
            w_sv[j]  = i_neg[j] ? (W+1)'(0) - w_qr[j] : w_qr[j];
            w_inv[j] = w_sat[j] ? (i_neg[j] ? MINV : MAXV) : w_sv[j][W-1:0];
            if (i_sing) begin
                w_inv[j] = (i_ctl.row == 2'(j)) ? DIAG : '0;
                w_sat[j] = (i_ctl.row == 2'(j)) && DIAG_OVF;
            end
        end
    end

    logic signed [SW-1:0] w_sum;
    logic [SW-1:0]        w_mag, w_rnd, w_tv;
    logic                 w_tneg, w_tsat;

    assign w_sum  = SW'(r2_p[0]) + SW'(r2_p[1]) + SW'(r2_p[2]);
    assign w_tneg = r3_ns[SW-1];
    assign w_mag  = w_tneg ? -r3_ns : r3_ns;
    assign w_rnd  = (w_mag + HALF) >> F;
    assign w_tsat = w_rnd > (w_tneg ? SW'(LIM_NEG) : SW'(LIM_POS));
    assign w_tv   = w_tneg ? -w_rnd : w_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_inv  <= w_inv;
            r1_ovf  <= |w_sat;
            r1_sing <= i_sing;
            for (int j = 0; j < 3; j++) begin
                r1_t[j] <= $signed(i_t[j]);
                r2_p[j] <= $signed(r1_inv[j]) * r1_t[j];
            end
            r2_inv  <= r1_inv;
            r2_ovf  <= r1_ovf;
            r2_sing <= r1_sing;

            r3_ns   <= -w_sum;
            r3_inv  <= r2_inv;
            r3_ovf  <= r2_ovf;
            r3_sing <= r2_sing;

            r4_c[0] <= r3_inv[0];
            r4_c[1] <= r3_inv[1];
            r4_c[2] <= r3_inv[2];
            r4_c[3] <= w_tsat ? (w_tneg ? MINV : MAXV) : w_tv[W-1:0];
            r4_ovf  <= r3_ovf || w_tsat;
            r4_sing <= r3_sing;
        end
    end

    assign o_valid = r4_ctl.valid;
    assign o_row   = r4_ctl.row;
    assign o_c     = r4_c;
    assign o_sing  = r4_sing;
    assign o_ovf   = r4_ovf;
    assign o_last  = (r4_ctl.row == ROW_LAST);

endmodule

FILE: rtl/affine_matrix_inverse_core.sv
// ----------------------------------------------------------------------------
// affine_matrix_inverse_core
// Inverse of a 3x4 affine matrix in signed fixed point, three rows per matrix.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                       | transfer
//  i_mat    | in  | r0c0..r2c3, twelve W-bit signed elements      | valid & ready
//  o_row    | out | row_index, out_c0..out_c3, singular, overflow, | valid & ready
//           |     | last                                          |
//
//  Throughput: one result row per cycle when o_row is not stalled; a new matrix
//  is taken as the held one issues row 2. The row sequencer issues one row slot
//  per cycle, save in a stall, into a single three-lane divider.
//  Stages: 7 front, W divider (one quotient bit each) and 4 back stages.
//  Reset: synchronous, active low; clears the sequencer and all stage valids.
//  Stalls: the whole pipeline, output register included, holds while a row
//  waits at o_row; bubbles travel as invalid slots and are dropped.
// ----------------------------------------------------------------------------
module affine_matrix_inverse_core #(
    parameter int W = aminv_pkg::WORD_BITS_DEF,
    parameter int F = aminv_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    aminv_mat_if.sink    i_mat,
    aminv_row_if.source  o_row
);
    import aminv_pkg::*;

    // Pipeline advance: output register free or being drained.
    logic w_en;
    logic w_out_valid;
    assign w_en = !w_out_valid || o_row.ready;

    // ---------------- row sequencer (stage 0) ----------------
    // Holds the matrix and issues rows 0, 1, 2 on consecutive advances. The
    // next matrix is taken in the same cycle that row 2 leaves.
    logic                   r_busy, n_busy;
    logic [1:0]             r_row,  n_row;
    logic [2:0][3:0][W-1:0] r_mat;
    logic                   w_take;

    assign i_mat.ready = w_en && (!r_busy || r_row == ROW_LAST);
    assign w_take      = i_mat.valid && i_mat.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= ROW_FIRST;
        end else begin
            r_busy <= n_busy;
            r_row  <= n_row;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_row  = r_row;
        if (w_take) begin
            n_busy = 1'b1;
            n_row  = ROW_FIRST;
        end else if (w_en && r_busy) begin
            if (r_row == ROW_LAST) begin
                n_busy = 1'b0;
            end else begin
                n_row = row_next(r_row);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_mat[0][0] <= i_mat.r0c0;
            r_mat[0][1] <= i_mat.r0c1;
            r_mat[0][2] <= i_mat.r0c2;
            r_mat[0][3] <= i_mat.r0c3;
            r_mat[1][0] <= i_mat.r1c0;
            r_mat[1][1] <= i_mat.r1c1;
            r_mat[1][2] <= i_mat.r1c2;
            r_mat[1][3] <= i_mat.r1c3;
            r_mat[2][0] <= i_mat.r2c0;
            r_mat[2][1] <= i_mat.r2c1;
            r_mat[2][2] <= i_mat.r2c2;
            r_mat[2][3] <= i_mat.r2c3;
        end
    end

    t_ctl w_slot;
    assign w_slot.valid = r_busy;
    assign w_slot.row   = r_row;

    // ---------------- front: cofactors, determinant, divider setup ----------
    t_ctl                w_f_ctl;
    logic [3*W+1:0]      w_f_d;
    logic [2:0][3*W+2:0] w_f_rem;
    logic [2:0][W-1:0]   w_f_nlo;
    logic [2:0]          w_f_neg, w_f_povf;
    logic                w_f_sing;
    logic [2:0][W-1:0]   w_f_t;

    aminv_front #(.W(W), .F(F)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_slot),
        .i_mat   (r_mat),
        .o_ctl   (w_f_ctl),
        .o_d     (w_f_d),
        .o_rem   (w_f_rem),
        .o_nlo   (w_f_nlo),
        .o_neg   (w_f_neg),
        .o_povf  (w_f_povf),
        .o_sing  (w_f_sing),
        .o_t     (w_f_t)
    );

    // ---------------- divider: adjugate * 2^2F / det, three lanes ----------
    t_ctl                w_d_ctl;
    logic [3*W+1:0]      w_d_d;
    logic [2:0][3*W+2:0] w_d_rem;
    logic [2:0][W-1:0]   w_d_q;
    logic [2:0]          w_d_neg, w_d_povf;
    logic                w_d_sing;
    logic [2:0][W-1:0]   w_d_t;

    aminv_div #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_f_ctl),
        .i_d     (w_f_d),
        .i_rem   (w_f_rem),
        .i_nlo   (w_f_nlo),
        .i_neg   (w_f_neg),
        .i_povf  (w_f_povf),
        .i_sing  (w_f_sing),
        .i_t     (w_f_t),
        .o_ctl   (w_d_ctl),
        .o_d     (w_d_d),
        .o_rem   (w_d_rem),
        .o_q     (w_d_q),
        .o_neg   (w_d_neg),
        .o_povf  (w_d_povf),
        .o_sing  (w_d_sing),
        .o_t     (w_d_t)
    );

    // ---------------- back: rounding, translation, output register ---------
    logic [1:0]        w_o_row;
    logic [3:0][W-1:0] w_o_c;
    logic              w_o_sing, w_o_ovf, w_o_last;

    aminv_back #(.W(W), .F(F)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_d_ctl),
        .i_d     (w_d_d),
        .i_rem   (w_d_rem),
        .i_q     (w_d_q),
        .i_neg   (w_d_neg),
        .i_povf  (w_d_povf),
        .i_sing  (w_d_sing),
        .i_t     (w_d_t),
        .o_valid (w_out_valid),
        .o_row   (w_o_row),
        .o_c     (w_o_c),
        .o_sing  (w_o_sing),
        .o_ovf   (w_o_ovf),
        .o_last  (w_o_last)
    );

    assign o_row.valid     = w_out_valid;
    assign o_row.row_index = w_o_row;
    assign o_row.out_c0    = w_o_c[0];
    assign o_row.out_c1    = w_o_c[1];
    assign o_row.out_c2    = w_o_c[2];
    assign o_row.out_c3    = w_o_c[3];
    assign o_row.singular  = w_o_sing;
    assign o_row.overflow  = w_o_ovf;
    assign o_row.last      = w_o_last;

`ifndef ASSERT_OFF
    // A new matrix only lands when the held one has issued its last row.
    a_take_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> (!r_busy || r_row == ROW_LAST))
        else $error("matrix taken while rows still pending");

    // After a transfer the sequencer starts over at row 0.
    a_take_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (r_busy && r_row == ROW_FIRST))
        else $error("sequencer did not restart after transfer");

    // A stalled result blocks the input side.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_row.valid && !o_row.ready) |-> !i_mat.ready)
        else $error("input accepted during output stall");

    // The last mark and the row index agree.
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_row.valid |-> (o_row.last == (o_row.row_index == ROW_LAST)))
        else $error("last mark disagrees with row index");
`endif

endmodule
